@@ rtl/core/kli_pkg.sv @@
// ----------------------------------------------------------------------------
// kli_pkg
// shared types and constants for the keyframe interpolator
// ----------------------------------------------------------------------------
package kli_pkg;

    // table depth, fixed by the 6-bit index and 7-bit count fields
    localparam int MAX_KEYS = 64;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_BADIX = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] time_value;
        logic [5:0]         entry_index;
        logic signed [31:0] in_scale_x;
        logic signed [31:0] in_scale_y;
        logic signed [31:0] in_scale_z;
        logic signed [31:0] in_pos_x;
        logic signed [31:0] in_pos_y;
        logic signed [31:0] in_pos_z;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic [6:0]         entry_count;
        logic signed [31:0] out_scale_x;
        logic signed [31:0] out_scale_y;
        logic signed [31:0] out_scale_z;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
    } t_res;

    // one table row: time then six vector components
    typedef struct packed {
        logic signed [31:0]      key_time;
        logic [5:0][31:0]        vec;
    } t_row;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_END_RD,
        S_END_WAIT,
        S_LAST_CHK,
        S_DIV,
        S_LERP,
        S_DONE
    } t_state;

endpackage

@@ rtl/core/kli_divider.sv @@
// ----------------------------------------------------------------------------
// kli_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module kli_divider #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [FRAC_BITS:0] o_quot
);
    localparam int QW = FRAC_BITS + 1;
    localparam int CW = $clog2(QW + 1);

    logic [32:0]   r_rem, n_rem;
    logic [32:0]   r_den;
    logic [QW-1:0] r_quot, n_quot;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [33:0]   w_trial;

    // quotient is below two, so only FRAC_BITS+1 bits are produced;
    // the numerator is num << FRAC_BITS fed one bit at a time
    always_comb begin
        w_trial = {r_rem, 1'b0};
        n_rem   = w_trial[32:0];
        n_quot  = {r_quot[QW-2:0], 1'b0};
        if (w_trial >= {1'b0, r_den}) begin
            n_rem  = 33'(w_trial - {1'b0, r_den});
            n_quot = {r_quot[QW-2:0], 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= r_busy && !i_start && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(FRAC_BITS);
                r_den  <= i_den;
                // integer bit of the quotient first
                if (i_num >= i_den) begin
                    r_rem  <= 33'(i_num - i_den);
                    r_quot <= QW'(1);
                end else begin
                    r_rem  <= i_num;
                    r_quot <= '0;
                end
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quot <= n_quot;
                r_cnt  <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_quot = r_quot;

endmodule

@@ rtl/core/kli_lerp.sv @@
// ----------------------------------------------------------------------------
// kli_lerp
// one component per cycle while i_en is high: a + floor((b - a) * f >> frac)
// ----------------------------------------------------------------------------
module kli_lerp #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    input  logic [FRAC_BITS:0] i_frac,
    output logic signed [31:0] o_res
);
    logic signed [32:0]           r_diff;
    logic signed [31:0]           r_a, r_a2;
    logic signed [33+FRAC_BITS:0] r_prod;
    logic signed [33+FRAC_BITS:0] w_shift;

    // stage one: difference, stage two: product, then a combinational add
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= 33'(i_b) - 33'(i_a);
            r_a    <= i_a;
        end
        r_prod <= r_diff * $signed({1'b0, i_frac});
        r_a2   <= r_a;
    end

    // arithmetic shift floors
    assign w_shift = r_prod >>> FRAC_BITS;
    assign o_res   = 32'(w_shift + (34 + FRAC_BITS)'(r_a2));

endmodule

@@ rtl/core/keyframe_linear_interpolator_unit.sv @@
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_unit
// keyframe table in one row memory with search, remove shift and lerp
// ----------------------------------------------------------------------------
//  channel | signals                      | direction
//  command | i_start, o_busy, i_cmd       | in, taken when start and not busy
//  result  | o_valid, o_res               | out, one-cycle strobe
//
//  add, unused command, empty query: straight to done. remove: a read and a
//  write per shifted row. query reads the first key, then the last unless at
//  or before the first or single; else reads and checks keys up to the upper
//  key via the single read port, then runs divider and lerp. the result strobe
//  follows the last busy cycle; reset clears the state, key count and control
//  flags only; table rows are written before read; the result cannot stall.
module keyframe_linear_interpolator_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  kli_pkg::t_cmd     i_cmd,
    output logic              o_busy,
    output logic              o_valid,
    output kli_pkg::t_res     o_res
);
    localparam int AW = $clog2(kli_pkg::MAX_KEYS);
    localparam int CW = $clog2(kli_pkg::MAX_KEYS + 1);

    kli_pkg::t_row mem [kli_pkg::MAX_KEYS];
    kli_pkg::t_row r_rd;
    logic          n_re;
    logic [AW-1:0] n_ra;
    logic          r_we, n_we;
    logic [AW-1:0] r_wa, n_wa;
    kli_pkg::t_row r_wd, n_wd;

    kli_pkg::t_state    r_st, n_st;
    kli_pkg::t_cmd      r_cmd, n_cmd;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]      r_k, n_k;
    kli_pkg::t_row      r_lo, n_lo;
    kli_pkg::t_row      r_hi, n_hi;
    logic [3:0]         r_lcnt, n_lcnt;
    logic [5:0][31:0]   r_vec, n_vec;
    logic [1:0]         r_status, n_status;
    logic [FRAC_BITS:0] r_frac, n_frac;
    logic               r_div_go, n_div_go;
    logic               n_valid;

    logic               w_bad_ix;
    logic [CW-1:0]      w_last;
    logic signed [31:0] w_tq;
    logic               w_div_done;
    logic [FRAC_BITS:0] w_quot;
    logic signed [31:0] w_lr;
    logic [32:0]        w_num, w_den;
    logic [2:0]         w_j;

    always_ff @(posedge i_clk) begin
        if (r_we) mem[r_wa] <= r_wd;
        if (n_re) r_rd <= mem[n_ra];
    end

    assign w_last   = r_cnt - CW'(1);
    assign w_bad_ix = (CW'(i_cmd.entry_index) >= r_cnt);
    assign w_tq     = r_cmd.time_value;

    always_comb begin
        n_st = r_st;
        case (r_st)
            kli_pkg::S_IDLE: begin
                if (i_start) begin
                    case (i_cmd.command)
                        kli_pkg::CMD_ADD:    n_st = kli_pkg::S_DONE;
                        kli_pkg::CMD_REMOVE:
                            n_st = w_bad_ix ? kli_pkg::S_DONE : kli_pkg::S_SHIFT_RD;
                        kli_pkg::CMD_QUERY:
                            n_st = (r_cnt == '0) ? kli_pkg::S_DONE : kli_pkg::S_END_RD;
                        default: n_st = kli_pkg::S_DONE;
                    endcase
                end
            end
            kli_pkg::S_SHIFT_RD:  n_st = (r_k + CW'(1) < r_cnt) ? kli_pkg::S_SHIFT_WR
                                                                 : kli_pkg::S_DONE;
            kli_pkg::S_SHIFT_WR:  n_st = kli_pkg::S_SHIFT_RD;
            kli_pkg::S_END_RD:    n_st = kli_pkg::S_END_WAIT;
            kli_pkg::S_END_WAIT:
                n_st = (r_cnt == CW'(1) || w_tq <= r_rd.key_time) ? kli_pkg::S_DONE
                                                                  : kli_pkg::S_LAST_CHK;
            kli_pkg::S_LAST_CHK:
                n_st = (w_tq >= r_rd.key_time) ? kli_pkg::S_DONE : kli_pkg::S_SRCH_RD;
            kli_pkg::S_SRCH_RD:   n_st = kli_pkg::S_SRCH_CHK;
            kli_pkg::S_SRCH_CHK:
                n_st = (w_tq < r_rd.key_time) ? kli_pkg::S_DIV : kli_pkg::S_SRCH_RD;
            kli_pkg::S_DIV:       n_st = w_div_done ? kli_pkg::S_LERP : kli_pkg::S_DIV;
            kli_pkg::S_LERP:      n_st = (r_lcnt == 4'd7) ? kli_pkg::S_DONE : kli_pkg::S_LERP;
            kli_pkg::S_DONE:      n_st = kli_pkg::S_IDLE;
            default:              n_st = kli_pkg::S_IDLE;
        endcase
    end

    // memory read address
    always_comb begin
        n_re = 1'b0;
        n_ra = '0;
        case (r_st)
            kli_pkg::S_SHIFT_RD: begin
                n_re = 1'b1;
                n_ra = AW'(r_k + CW'(1));
            end
            kli_pkg::S_END_RD: begin
                n_re = 1'b1;
                n_ra = '0;
            end
            kli_pkg::S_END_WAIT: begin
                n_re = 1'b1;
                n_ra = AW'(w_last);
            end
            kli_pkg::S_SRCH_RD: begin
                n_re = 1'b1;
                n_ra = AW'(r_k);
            end
            default: n_re = 1'b0;
        endcase
    end

    always_comb begin
        n_cmd    = r_cmd;
        n_cnt    = r_cnt;
        n_k      = r_k;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_lcnt   = r_lcnt;
        n_vec    = r_vec;
        n_status = r_status;
        n_frac   = r_frac;
        n_div_go = 1'b0;
        n_we     = 1'b0;
        n_wa     = r_wa;
        n_wd     = r_wd;
        n_valid  = 1'b0;
        case (r_st)
            kli_pkg::S_IDLE: begin
                if (i_start) begin
                    n_cmd    = i_cmd;
                    n_vec    = '0;
                    n_status = kli_pkg::ST_OK;
                    n_lcnt   = '0;
                    n_k      = CW'(i_cmd.entry_index);
                    case (i_cmd.command)
                        kli_pkg::CMD_ADD: begin
                            if (r_cnt == CW'(kli_pkg::MAX_KEYS)) begin
                                n_status = kli_pkg::ST_FULL;
                            end else begin
                                n_we  = 1'b1;
                                n_wa  = AW'(r_cnt);
                                n_wd  = {i_cmd.time_value, i_cmd.in_pos_z,
                                         i_cmd.in_pos_y, i_cmd.in_pos_x,
                                         i_cmd.in_scale_z, i_cmd.in_scale_y,
                                         i_cmd.in_scale_x};
                                n_cnt = r_cnt + CW'(1);
                            end
                        end
                        kli_pkg::CMD_REMOVE: begin
                            if (w_bad_ix)
                                n_status = kli_pkg::ST_BADIX;
                        end
                        kli_pkg::CMD_QUERY: begin
                            if (r_cnt == '0) begin
                                n_status = kli_pkg::ST_EMPTY;
                                n_vec[0] = 32'(1) << FRAC_BITS;
                                n_vec[1] = 32'(1) << FRAC_BITS;
                                n_vec[2] = 32'(1) << FRAC_BITS;
                            end
                        end
                        default: n_status = kli_pkg::ST_OK;
                    endcase
                end
            end
            kli_pkg::S_SHIFT_RD: begin
                if (!(r_k + CW'(1) < r_cnt))
                    n_cnt = r_cnt - CW'(1);
            end
            kli_pkg::S_SHIFT_WR: begin
                n_we = 1'b1;
                n_wa = AW'(r_k);
                n_wd = r_rd;
                n_k  = r_k + CW'(1);
            end
            kli_pkg::S_END_WAIT: begin
                // first key read; at or before it, or a single key, gives key 0
                n_lo = r_rd;
                if (r_cnt == CW'(1) || w_tq <= r_rd.key_time)
                    n_vec = r_rd.vec;
            end
            kli_pkg::S_LAST_CHK: begin
                if (w_tq >= r_rd.key_time)
                    n_vec = r_rd.vec;
                n_k = CW'(1);
            end
            kli_pkg::S_SRCH_CHK: begin
                // scan upward for the first key later than the query time
                if (w_tq < r_rd.key_time) begin
                    n_hi     = r_rd;
                    n_div_go = 1'b1;
                end else begin
                    n_lo = r_rd;
                    n_k  = r_k + CW'(1);
                end
            end
            kli_pkg::S_DIV: begin
                n_lcnt = '0;
                if (w_div_done) n_frac = w_quot;
            end
            kli_pkg::S_LERP: begin
                n_lcnt = r_lcnt + 4'd1;
                // lerp result trails its operands through the difference and product registers
                if (r_lcnt >= 4'd2)
                    n_vec[3'(r_lcnt - 4'd2)] = w_lr;
            end
            kli_pkg::S_DONE: n_valid = 1'b1;
            default: n_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= kli_pkg::S_IDLE;
            r_cnt    <= '0;
            r_we     <= 1'b0;
            r_div_go <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_cnt    <= n_cnt;
            r_we     <= n_we;
            r_div_go <= n_div_go;
            o_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_k      <= n_k;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_lcnt   <= n_lcnt;
        r_vec    <= n_vec;
        r_status <= n_status;
        r_frac   <= n_frac;
        r_wa     <= n_wa;
        r_wd     <= n_wd;
    end

    // r_lo holds the lower key and r_hi the upper once the search stops
    assign w_num = 33'(w_tq) - 33'(r_lo.key_time);
    assign w_den = 33'(r_hi.key_time) - 33'(r_lo.key_time);

    kli_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_go),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    assign w_j = (r_lcnt > 4'd5) ? 3'd5 : 3'(r_lcnt);

    kli_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
        .i_clk (i_clk),
        .i_en  (r_st == kli_pkg::S_LERP),
        .i_a   (r_lo.vec[w_j]),
        .i_b   (r_hi.vec[w_j]),
        .i_frac(r_frac),
        .o_res (w_lr)
    );

    assign o_busy = (r_st != kli_pkg::S_IDLE);

    always_comb begin
        o_res.status      = r_status;
        o_res.entry_count = 7'(r_cnt);
        o_res.out_scale_x = r_vec[0];
        o_res.out_scale_y = r_vec[1];
        o_res.out_scale_z = r_vec[2];
        o_res.out_pos_x   = r_vec[3];
        o_res.out_pos_y   = r_vec[4];
        o_res.out_pos_z   = r_vec[5];
    end

endmodule

@@ rtl/core/kli_checker.sv @@
// ----------------------------------------------------------------------------
// kli_checker
// port-level checks on the command and result beats
// ----------------------------------------------------------------------------
module kli_props (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_start,
    input logic          o_busy,
    input logic          o_valid,
    input kli_pkg::t_res o_res
);
    // a taken beat makes the unit busy
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("busy not raised");

    // result strobe is a single cycle
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe too long");

    // count never exceeds table depth at a result strobe
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.entry_count <= 7'(kli_pkg::MAX_KEYS)))
        else $error("count out of range");

    // full status only with a full table
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status == kli_pkg::ST_FULL)
        |-> (o_res.entry_count == 7'(kli_pkg::MAX_KEYS)))
        else $error("full with room left");
endmodule

bind keyframe_linear_interpolator_unit kli_props u_kli_props (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_start(i_start),
    .o_busy (o_busy),
    .o_valid(o_valid),
    .o_res  (o_res)
);
